FILE: rtl/core/metric_text_tokenizer_top_assert.svh
// Assertion macros for the metric text tokenizer checkers.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef METRIC_TEXT_TOKENIZER_TOP_ASSERT_SVH
`define METRIC_TEXT_TOKENIZER_TOP_ASSERT_SVH

// Checked outside reset.
`define MTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MTT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/mtt_pkg.sv
// Shared types and constants of the metric text tokenizer.
// No dependencies.
package mtt_pkg;

    // Scanner modes, one-hot.
    typedef enum logic [8:0] {
        M_LINE  = 9'b000000001,
        M_TYPE  = 9'b000000010,
        M_AKEY  = 9'b000000100,
        M_AVAL  = 9'b000001000,
        M_MKEY  = 9'b000010000,
        M_LPAIR = 9'b000100000,
        M_LKEY  = 9'b001000000,
        M_LVAL  = 9'b010000000,
        M_MVAL  = 9'b100000000
    } t_mode;

    // Token kind codes.
    localparam logic [3:0] K_ATTR_MARK    = 4'd0;
    localparam logic [3:0] K_TYPE         = 4'd1;
    localparam logic [3:0] K_KEY          = 4'd2;
    localparam logic [3:0] K_ATTR_VALUE   = 4'd3;
    localparam logic [3:0] K_METRIC_KEY   = 4'd4;
    localparam logic [3:0] K_LABEL_START  = 4'd5;
    localparam logic [3:0] K_LABEL_KEY    = 4'd6;
    localparam logic [3:0] K_LABEL_VALUE  = 4'd7;
    localparam logic [3:0] K_METRIC_VALUE = 4'd8;
    localparam logic [3:0] K_LABEL_END    = 4'd9;

    // Delimiter bytes.
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Result queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_BITS = 3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic [3:0] mode_kind(input t_mode mode);
        logic [3:0] kind;
        unique case (mode)
            M_TYPE:  kind = K_TYPE;
            M_AKEY:  kind = K_KEY;
            M_AVAL:  kind = K_ATTR_VALUE;
            M_MKEY:  kind = K_METRIC_KEY;
            M_LPAIR: kind = K_LABEL_START;
            M_LKEY:  kind = K_LABEL_KEY;
            M_LVAL:  kind = K_LABEL_VALUE;
            M_MVAL:  kind = K_METRIC_VALUE;
            default: kind = K_ATTR_MARK;
        endcase
        return kind;
    endfunction

endpackage

FILE: rtl/core/mtt_scan.sv
// Byte scanner: mode, position and open-token registers plus token decode.
// Depends on mtt_pkg.
module mtt_scan #(
    parameter int OFFSET_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_text_byte,
    input  logic          i_end_of_text,
    output mtt_pkg::t_push o_push
);
    import mtt_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFS_ONE = OFFSET_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] OFS_TWO = OFFSET_BITS'(2);

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_open, n_open;
    logic                   r_skip, n_skip;

    t_mode                  mode_e;
    logic [OFFSET_BITS-1:0] open_e;
    logic [OFFSET_BITS-1:0] len;
    logic [OFFSET_BITS-1:0] size;
    logic                   fresh;
    logic [1:0]             cnt;
    t_token                 ta, tb;

    function automatic t_token mk(input logic [3:0] kind,
                                  input logic [OFFSET_BITS-1:0] st,
                                  input logic [OFFSET_BITS-1:0] ln);
        t_token t;
        t.kind   = kind;
        t.start  = 16'(st);
        t.length = 16'(ln);
        t.last   = 1'b0;
        return t;
    endfunction

    // Label value text drops its first and last byte; shorter values keep their start.
    function automatic t_token label_value(input logic [OFFSET_BITS-1:0] st,
                                           input logic [OFFSET_BITS-1:0] sz);
        t_token t;
        if (sz >= OFS_TWO) begin
            t = mk(K_LABEL_VALUE, st + OFS_ONE, sz - OFS_TWO);
        end else begin
            t = mk(K_LABEL_VALUE, st, '0);
        end
        return t;
    endfunction

    always_comb begin
        n_mode = r_mode;
        n_pos  = r_pos;
        n_open = r_open;
        n_skip = r_skip;
        mode_e = r_mode;
        open_e = r_open;
        len    = '0;
        size   = '0;
        fresh  = 1'b0;
        cnt    = 2'd0;
        ta     = '0;
        tb     = '0;

        if (r_skip) begin
            n_skip = 1'b0;
            fresh  = 1'b1;
        end else begin
            if (r_mode == M_LINE && i_text_byte != CH_HASH) begin
                mode_e = M_MKEY;
                open_e = r_pos;
            end
            if (r_mode == M_LPAIR && i_text_byte != CH_RBRACE) begin
                mode_e = M_LKEY;
                open_e = r_pos;
            end
            len    = r_pos - open_e;
            n_mode = mode_e;
            n_open = open_e;

            unique case (mode_e)
                M_LINE: begin
                    ta     = mk(K_ATTR_MARK, r_pos, '0);
                    cnt    = 2'd1;
                    n_skip = 1'b1;
                    n_open = r_pos + OFS_TWO;
                    n_mode = M_TYPE;
                    fresh  = 1'b1;
                end
                M_TYPE, M_AKEY: begin
                    if (i_text_byte == CH_SPACE) begin
                        ta     = mk(mode_kind(mode_e), open_e, len);
                        cnt    = 2'd1;
                        n_open = r_pos + OFS_ONE;
                        n_mode = (mode_e == M_TYPE) ? M_AKEY : M_AVAL;
                        fresh  = 1'b1;
                    end
                end
                M_AVAL, M_MVAL: begin
                    if (i_text_byte == CH_NEWLINE) begin
                        ta     = mk(mode_kind(mode_e), open_e, len);
                        cnt    = 2'd1;
                        n_mode = M_LINE;
                        fresh  = 1'b1;
                    end
                end
                M_MKEY: begin
                    if (i_text_byte == CH_LBRACE) begin
                        ta     = mk(K_METRIC_KEY, open_e, len);
                        tb     = mk(K_LABEL_START, r_pos, '0);
                        cnt    = 2'd2;
                        n_mode = M_LPAIR;
                        fresh  = 1'b1;
                    end else if (i_text_byte == CH_SPACE) begin
                        ta     = mk(K_METRIC_KEY, open_e, len);
                        cnt    = 2'd1;
                        n_open = r_pos + OFS_ONE;
                        n_mode = M_MVAL;
                        fresh  = 1'b1;
                    end
                end
                M_LPAIR: begin
                    // closing brace at the start of a pair: skip one separator
                    ta     = mk(K_LABEL_END, r_pos, '0);
                    cnt    = 2'd1;
                    n_skip = 1'b1;
                    n_open = r_pos + OFS_TWO;
                    n_mode = M_MVAL;
                    fresh  = 1'b1;
                end
                M_LKEY: begin
                    if (i_text_byte == CH_EQUAL) begin
                        ta     = mk(K_LABEL_KEY, open_e, len);
                        cnt    = 2'd1;
                        n_open = r_pos + OFS_ONE;
                        n_mode = M_LVAL;
                        fresh  = 1'b1;
                    end
                end
                M_LVAL: begin
                    if (i_text_byte == CH_COMMA) begin
                        ta     = label_value(open_e, len);
                        cnt    = 2'd1;
                        n_mode = M_LPAIR;
                        fresh  = 1'b1;
                    end else if (i_text_byte == CH_RBRACE) begin
                        ta     = label_value(open_e, len);
                        tb     = mk(K_LABEL_END, r_pos, '0);
                        cnt    = 2'd2;
                        n_skip = 1'b1;
                        n_open = r_pos + OFS_TWO;
                        n_mode = M_MVAL;
                        fresh  = 1'b1;
                    end
                end
                default: begin
                    n_mode = M_LINE;
                end
            endcase
        end

        if (i_end_of_text) begin
            // close a token that already holds bytes, then start over
            if (!fresh && n_mode != M_LINE && n_mode != M_LPAIR) begin
                size = r_pos + OFS_ONE - n_open;
                if (n_mode == M_LVAL) begin
                    ta = label_value(n_open, size);
                end else begin
                    ta = mk(mode_kind(n_mode), n_open, size);
                end
                cnt = 2'd1;
            end
            n_mode = M_LINE;
            n_pos  = '0;
            n_open = '0;
            n_skip = 1'b0;
        end else begin
            n_pos = r_pos + OFS_ONE;
        end

        if (cnt == 2'd1) begin
            ta.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            tb.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_LINE;
            r_pos  <= '0;
            r_open <= '0;
            r_skip <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_open <= n_open;
            r_skip <= n_skip;
        end
    end

    assign o_push.count = i_accept ? cnt : 2'd0;
    assign o_push.tok0  = ta;
    assign o_push.tok1  = tb;

endmodule

FILE: rtl/core/mtt_queue.sv
// Result queue: shifting register slots, takes up to two words, gives one.
// Depends on mtt_pkg.
module mtt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mtt_pkg::t_push  i_push,
    output logic            o_space,
    output logic            o_valid,
    input  logic            i_ready,
    output mtt_pkg::t_token o_token
);
    import mtt_pkg::*;

    t_token                 r_slot [QUEUE_DEPTH];
    t_token                 n_slot [QUEUE_DEPTH];
    logic [QCOUNT_BITS-1:0] r_count, n_count;
    logic [QCOUNT_BITS-1:0] kept;
    logic                   pop;

    assign pop  = (r_count != '0) && i_ready;
    assign kept = r_count - QCOUNT_BITS'(pop);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            // advance on pop, then append new words behind what is kept
            if (pop && i < QUEUE_DEPTH - 1) begin
                n_slot[i] = r_slot[i + 1];
            end else begin
                n_slot[i] = r_slot[i];
            end
            if (QCOUNT_BITS'(i) == kept) begin
                n_slot[i] = i_push.tok0;
            end else if (QCOUNT_BITS'(i) == kept + QCOUNT_BITS'(1)) begin
                n_slot[i] = i_push.tok1;
            end
        end
        n_count = kept + QCOUNT_BITS'(i_push.count);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_space = r_count <= QCOUNT_BITS'(QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_token = r_slot[0];

endmodule

FILE: rtl/core/metric_text_tokenizer_top.sv
// Top level of the metric text tokenizer.
// Depends on mtt_pkg, mtt_scan and mtt_queue.
//
// Takes exposition text one byte per word and returns token descriptors
// (kind, start offset, length, last-of-byte flag). Each byte is decoded in
// the cycle it is taken and gives zero, one or two descriptors, which go
// into a four-entry output queue; each result is registered in the queue
// before it leaves. A byte is taken whenever the queue holds at most
// two descriptors, so with the output side always ready the block takes one
// byte per cycle; bytes giving two descriptors ('{' after a metric key, '}'
// after a label value) need two output words, so a run of them is held back
// by the single-word output port. Offsets are OFFSET_BITS wide, wrap, and
// are shown as their low 16 bits.
module metric_text_tokenizer_top #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);
    import mtt_pkg::*;

    t_push  push;
    t_token head;
    logic   space;

    assign o_in_ready = space;

    mtt_scan #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (i_in_valid && space),
        .i_text_byte  (i_text_byte),
        .i_end_of_text(i_end_of_text),
        .o_push       (push)
    );

    mtt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_space(space),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_token(head)
    );

    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.length;
    assign o_last_of_run  = head.last;

endmodule

FILE: rtl/core/mtt_checker.sv
// Port-level checks for metric_text_tokenizer_top, attached by bind.
// Depends on mtt_pkg and metric_text_tokenizer_top_assert.svh.
`include "metric_text_tokenizer_top_assert.svh"

module mtt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_text_byte,
    input logic        i_end_of_text,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_token_kind,
    input logic [15:0] o_token_start,
    input logic [15:0] o_token_length,
    input logic        o_last_of_run
);
    import mtt_pkg::*;

    `MTT_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> o_in_ready && !o_out_valid, "queue not empty after reset")
    `MTT_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_token_kind) && $stable(o_token_start) && $stable(o_token_length) && $stable(o_last_of_run), "stalled word changed")
    `MTT_ASSERT(a_kind_range, o_out_valid |-> o_token_kind <= K_LABEL_END, "kind out of range")
    `MTT_ASSERT(a_mark_empty, o_out_valid && (o_token_kind == K_ATTR_MARK || o_token_kind == K_LABEL_START || o_token_kind == K_LABEL_END) |-> o_token_length == 16'd0, "mark with text")
    `MTT_ASSERT(a_stall_backlog, !o_in_ready |-> o_out_valid, "input stalled with empty output")

endmodule

bind metric_text_tokenizer_top mtt_checker u_mtt_checker (.*);

FILE: tb/metric_text_tokenizer_checker.sv
// Scoreboard for the metric text tokenizer: watches both channels, predicts tokens.
// Depends on mtt_pkg; the top testbench instantiates it beside the block.
`timescale 1ns / 1ps

module metric_text_tokenizer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_token_kind,
    input  logic [15:0] i_token_start,
    input  logic [15:0] i_token_length,
    input  logic        i_last_of_run,
    output int          o_error_count,
    output int          o_tokens_owed
);
    import mtt_pkg::*;

    t_mode       scan_mode;
    logic [15:0] byte_pos;
    logic [15:0] tok_start;
    logic        skip_next;
    t_token      expected_tokens[$];
    int          error_count = 0;

    function automatic void clear_scan();
        scan_mode = M_LINE;
        byte_pos  = '0;
        tok_start = '0;
        skip_next = 1'b0;
    endfunction

    function automatic logic [3:0] kind_for_mode(input t_mode mode);
        case (mode)
            M_TYPE:  return K_TYPE;
            M_AKEY:  return K_KEY;
            M_AVAL:  return K_ATTR_VALUE;
            M_MKEY:  return K_METRIC_KEY;
            M_LKEY:  return K_LABEL_KEY;
            M_MVAL:  return K_METRIC_VALUE;
            default: return K_ATTR_MARK;
        endcase
    endfunction

    function automatic void push_token(input logic [3:0] kind, input logic [15:0] start,
                                       input logic [15:0] tok_len);
        t_token tok;
        tok.kind   = kind;
        tok.start  = start;
        tok.length = tok_len;
        tok.last   = 1'b0;
        expected_tokens.push_back(tok);
    endfunction

    // Label values lose their first and last byte; shorter ones keep their start.
    function automatic void push_label_value(input logic [15:0] start, input logic [15:0] size);
        if (size >= 16'd2)
            push_token(K_LABEL_VALUE, start + 16'd1, size - 16'd2);
        else
            push_token(K_LABEL_VALUE, start, 16'd0);
    endfunction

    function automatic void predict_byte(input logic [7:0] c, input logic eot);
        logic [15:0] pos;
        logic [15:0] span;
        logic        fresh;
        int          first;
        t_token      tail;
        pos   = byte_pos;
        fresh = 1'b0;
        first = expected_tokens.size();
        if (skip_next) begin
            skip_next = 1'b0;
            fresh     = 1'b1;
        end else begin
            if (scan_mode == M_LINE && c != CH_HASH) begin
                scan_mode = M_MKEY;
                tok_start = pos;
            end
            if (scan_mode == M_LPAIR && c != CH_RBRACE) begin
                scan_mode = M_LKEY;
                tok_start = pos;
            end
            span = pos - tok_start;
            case (scan_mode)
                M_LINE: begin
                    push_token(K_ATTR_MARK, pos, 16'd0);
                    skip_next = 1'b1;
                    tok_start = pos + 16'd2;
                    scan_mode = M_TYPE;
                    fresh     = 1'b1;
                end
                M_TYPE, M_AKEY: begin
                    if (c == CH_SPACE) begin
                        push_token(kind_for_mode(scan_mode), tok_start, span);
                        tok_start = pos + 16'd1;
                        scan_mode = (scan_mode == M_TYPE) ? M_AKEY : M_AVAL;
                        fresh     = 1'b1;
                    end
                end
                M_AVAL, M_MVAL: begin
                    if (c == CH_NEWLINE) begin
                        push_token(kind_for_mode(scan_mode), tok_start, span);
                        scan_mode = M_LINE;
                        fresh     = 1'b1;
                    end
                end
                M_MKEY: begin
                    if (c == CH_LBRACE) begin
                        push_token(K_METRIC_KEY, tok_start, span);
                        push_token(K_LABEL_START, pos, 16'd0);
                        scan_mode = M_LPAIR;
                        fresh     = 1'b1;
                    end else if (c == CH_SPACE) begin
                        push_token(K_METRIC_KEY, tok_start, span);
                        tok_start = pos + 16'd1;
                        scan_mode = M_MVAL;
                        fresh     = 1'b1;
                    end
                end
                M_LPAIR: begin
                    // closing brace right at the start of a pair
                    push_token(K_LABEL_END, pos, 16'd0);
                    skip_next = 1'b1;
                    tok_start = pos + 16'd2;
                    scan_mode = M_MVAL;
                    fresh     = 1'b1;
                end
                M_LKEY: begin
                    if (c == CH_EQUAL) begin
                        push_token(K_LABEL_KEY, tok_start, span);
                        tok_start = pos + 16'd1;
                        scan_mode = M_LVAL;
                        fresh     = 1'b1;
                    end
                end
                M_LVAL: begin
                    if (c == CH_COMMA || c == CH_RBRACE) begin
                        push_label_value(tok_start, span);
                        if (c == CH_COMMA) begin
                            scan_mode = M_LPAIR;
                        end else begin
                            push_token(K_LABEL_END, pos, 16'd0);
                            skip_next = 1'b1;
                            tok_start = pos + 16'd2;
                            scan_mode = M_MVAL;
                        end
                        fresh = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (eot) begin
            // close a token that already holds bytes, counting this one
            if (!fresh && scan_mode != M_LINE && scan_mode != M_LPAIR) begin
                span = pos + 16'd1 - tok_start;
                if (scan_mode == M_LVAL)
                    push_label_value(tok_start, span);
                else
                    push_token(kind_for_mode(scan_mode), tok_start, span);
            end
            clear_scan();
        end else begin
            byte_pos = pos + 16'd1;
        end
        if (expected_tokens.size() > first) begin
            tail      = expected_tokens.pop_back();
            tail.last = 1'b1;
            expected_tokens.push_back(tail);
        end
    endfunction

    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            clear_scan();
            expected_tokens.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_byte(i_text_byte, i_end_of_text);
            if (i_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token: kind %0d start %0d length %0d",
                           i_token_kind, i_token_start, i_token_length);
                    error_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_token_kind !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, i_token_kind);
                        error_count++;
                    end
                    if (i_token_start !== want.start) begin
                        $error("token_start: expected %0d, got %0d", want.start, i_token_start);
                        error_count++;
                    end
                    if (i_token_length !== want.length) begin
                        $error("token_length: expected %0d, got %0d",
                               want.length, i_token_length);
                        error_count++;
                    end
                    if (i_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last, i_last_of_run);
                        error_count++;
                    end
                end
            end
        end
        o_error_count <= error_count;
        o_tokens_owed <= expected_tokens.size();
    end

endmodule

FILE: tb/tb_metric_text_tokenizer_top.sv
// Top testbench of the metric text tokenizer: clock, reset, byte stimulus and verdict.
// Depends on mtt_pkg, metric_text_tokenizer_top and metric_text_tokenizer_checker.
`timescale 1ns / 1ps

module tb_metric_text_tokenizer_top;
    import mtt_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam int HOLD_CYCLES       = 80;
    localparam int DRAIN_CYCLES      = 8;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_text_byte   = 8'h00;
    logic        i_end_of_text = 1'b0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_token_kind;
    logic [15:0] o_token_start;
    logic [15:0] o_token_length;
    logic        o_last_of_run;

    int          error_count;
    int          tokens_owed;
    int          words_sent    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          allow_eot     = 1'b1;
    logic        out_hold;
    event        hold_request;
    logic [7:0]  line_q[$];

    metric_text_tokenizer_top #(.OFFSET_BITS(16)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_token_kind  (o_token_kind),
        .o_token_start (o_token_start),
        .o_token_length(o_token_length),
        .o_last_of_run (o_last_of_run)
    );

    metric_text_tokenizer_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_token_kind  (o_token_kind),
        .i_token_start (o_token_start),
        .i_token_length(o_token_length),
        .i_last_of_run (o_last_of_run),
        .o_error_count (error_count),
        .o_tokens_owed (tokens_owed)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= !out_hold && ($urandom_range(99) >= stall_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    initial begin
        out_hold = 1'b0;
        forever begin
            @(hold_request);
            out_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            out_hold <= 1'b0;
        end
    end

    initial begin
        #5ms;
        $display("tb_metric_text_tokenizer_top: errors");
        $finish;
    end

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == CH_HASH || b == CH_LBRACE || b == CH_RBRACE || b == CH_COMMA ||
               b == CH_NEWLINE || b == CH_EQUAL || b == CH_SPACE);
        return b;
    endfunction

    function automatic logic [7:0] value_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == CH_NEWLINE);
        return b;
    endfunction

    function automatic logic [7:0] noisy_byte();
        case ($urandom_range(9))
            0:       return CH_HASH;
            1:       return CH_LBRACE;
            2:       return CH_RBRACE;
            3:       return CH_COMMA;
            4:       return CH_NEWLINE;
            5:       return CH_EQUAL;
            6:       return CH_SPACE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_word(input int lo, input int hi);
        repeat ($urandom_range(hi, lo)) line_q.push_back(plain_byte());
    endtask

    task automatic build_comment();
        line_q.push_back(CH_HASH);
        line_q.push_back(8'($urandom_range(255)));
        add_word(0, 6);
        line_q.push_back(CH_SPACE);
        add_word(0, 8);
        line_q.push_back(CH_SPACE);
        repeat ($urandom_range(10)) line_q.push_back(value_byte());
        line_q.push_back(CH_NEWLINE);
    endtask

    task automatic build_metric(input bit with_labels);
        int pairs;
        add_word(0, 8);
        if (with_labels) begin
            line_q.push_back(CH_LBRACE);
            pairs = $urandom_range(3);
            for (int p = 0; p < pairs; p++) begin
                if (p > 0)
                    line_q.push_back(CH_COMMA);
                add_word(0, 4);
                // a brace inside a key, not at its start, is plain text
                if ($urandom_range(7) == 0) begin
                    line_q.push_back(plain_byte());
                    line_q.push_back(CH_RBRACE);
                end
                line_q.push_back(CH_EQUAL);
                if ($urandom_range(3) == 0) begin
                    add_word(0, 1);
                end else begin
                    line_q.push_back(CH_QUOTE);
                    add_word(0, 6);
                    line_q.push_back(CH_QUOTE);
                end
            end
            if (pairs > 0 && $urandom_range(5) == 0)
                line_q.push_back(CH_COMMA);
            line_q.push_back(CH_RBRACE);
            line_q.push_back(8'($urandom_range(255)));
        end else begin
            line_q.push_back(CH_SPACE);
        end
        repeat ($urandom_range(8)) line_q.push_back(value_byte());
        line_q.push_back(CH_NEWLINE);
    endtask

    task automatic build_random_line(output bit eot_last);
        int pick;
        int keep;
        pick     = $urandom_range(99);
        eot_last = allow_eot && ($urandom_range(9) == 0);
        if (pick < 35) begin
            build_metric(1'b1);
        end else if (pick < 55) begin
            build_metric(1'b0);
        end else if (pick < 75) begin
            build_comment();
        end else if (pick < 87) begin
            repeat ($urandom_range(8, 1)) line_q.push_back(noisy_byte());
            eot_last = allow_eot;
        end else begin
            // cut a record short, usually in the middle of a token
            if ($urandom_range(1))
                build_metric(1'b1);
            else
                build_comment();
            keep = $urandom_range(line_q.size(), 1);
            while (line_q.size() > keep) void'(line_q.pop_back());
            eot_last = allow_eot;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk);
        while (!o_in_ready);
        words_sent++;
    endtask

    task automatic send_line(input bit eot_last);
        foreach (line_q[i])
            send_byte(line_q[i], eot_last && (i == line_q.size() - 1));
        line_q.delete();
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tokens_owed != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall, input int n_words);
        int stop_at;
        bit eot_last;
        send_idle_pct = idle_pct;
        stall_pct    <= stall;
        stop_at       = words_sent + n_words;
        while (words_sent < stop_at) begin
            build_random_line(eot_last);
            send_line(eot_last);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // comment line, label list with empty and short values, brace inside
        // a key, skipped byte after the list, end of text inside a value
        line_q = '{CH_HASH, 8'hFF, "T", CH_SPACE, "K", CH_SPACE, "V", CH_NEWLINE,
                   "m", CH_LBRACE, CH_RBRACE, 8'h00, "1", CH_NEWLINE,
                   CH_LBRACE, "k", CH_RBRACE, CH_EQUAL, CH_COMMA, CH_EQUAL,
                   "a", "b", CH_RBRACE, "_", "7"};
        send_line(1'b1);
        wait_drained();

        run_phase(0, 0, 200);
        // fill the output queue while the receiver holds off
        -> hold_request;
        repeat (3) build_metric(1'b1);
        send_line(1'b0);
        wait_drained();

        run_phase(55, 0, 220);
        wait_drained();
        run_phase(0, 55, 220);
        wait_drained();
        run_phase(15, 15, 220);
        wait_drained();

        run_phase(0, 15, 200);
        send_byte("x", 1'b1);
        wait_drained();

        if (error_count == 0)
            $display("tb_metric_text_tokenizer_top: clean");
        else
            $display("tb_metric_text_tokenizer_top: errors");
        $finish;
    end

endmodule
